FILE: design/ratio_feedforward_lead_lag_deadtime_macros.svh
// Assertion macros shared by the ratio feedforward compensator RTL.
`ifndef RATIO_FEEDFORWARD_LEAD_LAG_DEADTIME_MACROS_SVH
`define RATIO_FEEDFORWARD_LEAD_LAG_DEADTIME_MACROS_SVH
`ifndef SYNTH
`define RFFL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rffl: check failed");
`define RFFL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rffl: check failed");
`else
`define RFFL_ASSERT_IMP(lbl, ante, cons)
`define RFFL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/rffl_pkg.sv
// Shared constants and types of the ratio feedforward compensator.
`default_nettype none
package rffl_pkg;
    localparam int SAMPLE_W    = 32;
    localparam int DELAY_DEPTH = 256;
    localparam int RING_AW     = $clog2(DELAY_DEPTH);
    localparam int CFG_W       = 32;
    localparam int CFG_AW      = 4;
    localparam int DIV_NUM_W   = 51;
    localparam int DIV_DEN_W   = 34;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

    localparam logic [CFG_AW-1:0] REG_GAIN    = 4'd0;
    localparam logic [CFG_AW-1:0] REG_LEAD    = 4'd1;
    localparam logic [CFG_AW-1:0] REG_LAG     = 4'd2;
    localparam logic [CFG_AW-1:0] REG_DEAD    = 4'd3;
    localparam logic [CFG_AW-1:0] REG_OUT_MIN = 4'd4;
    localparam logic [CFG_AW-1:0] REG_OUT_MAX = 4'd5;
    localparam logic [CFG_AW-1:0] REG_MODE    = 4'd6;
    localparam logic [CFG_AW-1:0] REG_COMBINE = 4'd7;

    localparam logic [2:0] MODE_STATIC   = 3'd0;
    localparam logic [2:0] MODE_LEADLAG  = 3'd1;
    localparam logic [2:0] MODE_DEADTIME = 3'd2;
    localparam logic [2:0] MODE_BOTH     = 3'd3;

    localparam logic COMBINE_ADD = 1'b0;
    localparam logic COMBINE_MUL = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_STEP = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: design/rffl_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rffl_div import rffl_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   trial_sub;
    logic                 fits;

    always_comb begin
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

FILE: design/ratio_feedforward_lead_lag_deadtime.sv
// Ratio feedforward compensator: gain, Tustin lead-lag, dead-time ring, clamp, combine.
// One item at a time; s_tready is high only while the block is idle. An item with a zero
// time step goes from acceptance straight to the output state; a pass-through item runs
// through the gain multiply, rounding, clamp and combine states (and a second combine state
// with the multiplicative combine). s_tready rises with the load of the output register.
// Both lead-lag coefficients and the dead-time step count run on one shared bit-serial
// divider; the substitute lag (lead/10) uses a reciprocal multiply. Lead-lag is skipped when
// lead and lag are both zero; the dead-time ring is skipped when the dead time is zero or
// the delay rounds to zero steps. Both modes run lead-lag and then dead time.
// A result still waiting on m_tready stalls the next item only when that item reaches the
// output stage. The delay ring is a 256 x 32 synchronous memory with one valid bit per
// entry that reset clears, so no clearing pass is needed.
`default_nettype none
`include "ratio_feedforward_lead_lag_deadtime_macros.svh"
module ratio_feedforward_lead_lag_deadtime import rffl_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // master_sample [31:0], feedback_signal [63:32], time_step [95:64]
    input  wire logic [95:0]       s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // total_drive [31:0], ff_part [63:32]
    output logic [63:0]            m_tdata,
    // status [0]
    output logic [0:0]             m_tuser
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MULG  = 5'd1;
    localparam logic [4:0] ST_RAW   = 5'd2;
    localparam logic [4:0] ST_LL0   = 5'd3;
    localparam logic [4:0] ST_LAGW  = 5'd4;
    localparam logic [4:0] ST_DEN   = 5'd5;
    localparam logic [4:0] ST_CA    = 5'd6;
    localparam logic [4:0] ST_CAW   = 5'd7;
    localparam logic [4:0] ST_CB    = 5'd8;
    localparam logic [4:0] ST_CBW   = 5'd9;
    localparam logic [4:0] ST_M1    = 5'd10;
    localparam logic [4:0] ST_M2    = 5'd11;
    localparam logic [4:0] ST_M3    = 5'd12;
    localparam logic [4:0] ST_M4    = 5'd13;
    localparam logic [4:0] ST_DT0   = 5'd14;
    localparam logic [4:0] ST_DTW   = 5'd15;
    localparam logic [4:0] ST_WR    = 5'd16;
    localparam logic [4:0] ST_RD    = 5'd17;
    localparam logic [4:0] ST_RDU   = 5'd18;
    localparam logic [4:0] ST_CLAMP = 5'd19;
    localparam logic [4:0] ST_COMB  = 5'd20;
    localparam logic [4:0] ST_COMB2 = 5'd21;
    localparam logic [4:0] ST_OUT   = 5'd22;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
    localparam logic [DIV_NUM_W-1:0] COEF_MAX = DIV_NUM_W'(64'd2147483647);
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(DELAY_DEPTH - 1);
    // ceil(2^34 / 5): exact floor division by 5 for any 32-bit operand
    localparam logic [31:0] LAG_RECIP = 32'd3435973837;

    function automatic logic signed [31:0] sat_r16(input logic signed [65:0] v);
        logic signed [65:0] t;
        begin
            t = (v + 66'sd32768) >>> 16;
            if (t > SAT_HI) t = SAT_HI;
            if (t < SAT_LO) t = SAT_LO;
            return t[31:0];
        end
    endfunction

    // configuration
    logic signed [31:0] gain_reg, out_min_reg, out_max_reg;
    logic [31:0] lead_reg, lag_cfg_reg, dead_reg;
    logic [2:0]  mode_reg;
    logic        combine_reg;

    // item and working registers
    logic [4:0]  state_reg, state_next;
    logic signed [31:0] master_reg, fb_reg, x_reg, ff_reg, total_reg, mem_reg;
    logic signed [31:0] ca_reg, cb_reg;
    logic [31:0] step_reg, lag_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic        ca_neg_reg, status_reg;
    logic signed [64:0] pa_reg, pb_reg;
    logic signed [65:0] sum_reg;
    logic [RING_AW-1:0] wp_reg, steps_reg;
    logic signed [31:0] rdata_reg;
    logic        rvalid_reg;
    logic signed [31:0] ring_mem [DELAY_DEPTH];
    logic [DELAY_DEPTH-1:0] ring_valid_reg;
    logic [63:0] lag_prod_reg;

    // output register
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_user_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [33:0] lag_diff;
    logic [33:0] lag_mag;
    logic [30:0] q_sat;
    logic signed [31:0] coef;
    logic signed [31:0] clamp_v;
    logic signed [32:0] add_sum;
    logic signed [31:0] add_sat;
    logic [RING_AW-1:0] rd_addr, wp_inc;
    logic [4:0]  after_ll;
    logic        out_free, accept;
    logic [31:0] lag_q;
    logic [32:0] lag_sum;
    logic [31:0] lag_half;

    rffl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign after_ll = (mode_reg == MODE_BOTH) ? ST_DT0 : ST_CLAMP;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MULG: begin
                mul_a = gain_reg;
                mul_b = 33'(master_reg);
            end
            ST_M1: begin
                mul_a = ca_reg;
                mul_b = 33'(mem_reg);
            end
            ST_M2: begin
                mul_a = cb_reg;
                mul_b = 33'(x_reg);
            end
            ST_COMB: begin
                mul_a = ff_reg;
                mul_b = 33'(fb_reg) + 33'sd65536;
            end
            default: ;
        endcase
        mul_p = 65'(mul_a) * 65'(mul_b);
    end

    // divider operands and result shaping
    always_comb begin
        lag_diff = $signed({2'b00, lag_reg}) - $signed({2'b00, lead_reg});
        lag_mag  = lag_diff[33] ? 34'(-lag_diff) : 34'(lag_diff);
        div_req  = '0;
        case (state_reg)
            ST_CA: begin
                div_req.start = 1'b1;
                div_req.num   = (DIV_NUM_W'(lag_mag) << 17) + DIV_NUM_W'(den_reg >> 1);
                div_req.den   = den_reg;
            end
            ST_CB: begin
                div_req.start = 1'b1;
                div_req.num   = ((DIV_NUM_W'(lead_reg) << 1) + DIV_NUM_W'(step_reg)) << 16;
                div_req.num   = div_req.num + DIV_NUM_W'(den_reg >> 1);
                div_req.den   = den_reg;
            end
            ST_DT0: begin
                div_req.start = (dead_reg != '0);
                div_req.num   = (DIV_NUM_W'(dead_reg) << 1) + DIV_NUM_W'(step_reg);
                div_req.den   = DIV_DEN_W'(step_reg) << 1;
            end
            default: ;
        endcase
        q_sat   = (div_rsp.quo > COEF_MAX) ? 31'h7fffffff : div_rsp.quo[30:0];
        // (lead + 5) / 10 as ((lead + 5) >> 1) / 5
        lag_sum  = {1'b0, lead_reg} + 33'd5;
        lag_half = lag_sum[32:1];
        lag_q    = {2'b00, lag_prod_reg[63:34]};
        clamp_v = (x_reg > out_max_reg) ? out_max_reg : x_reg;
        if (clamp_v < out_min_reg) clamp_v = out_min_reg;
        add_sum = 33'(ff_reg) + 33'(fb_reg);
        if (add_sum > 33'sd2147483647) add_sat = 32'sh7fffffff;
        else if (add_sum < -33'sd2147483648) add_sat = 32'sh80000000;
        else add_sat = add_sum[31:0];
        wp_inc  = (wp_reg == RING_LAST) ? '0 : wp_reg + 1'b1;
        rd_addr = (wp_reg >= steps_reg) ? wp_reg - steps_reg
                : RING_AW'(DELAY_DEPTH - 32'(steps_reg) + 32'(wp_reg));
    end

    always_comb begin
        coef = ca_neg_reg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = (s_tdata[95:64] == '0) ? ST_OUT : ST_MULG;
            ST_MULG:  state_next = ST_RAW;
            ST_RAW: begin
                if (mode_reg == MODE_LEADLAG || mode_reg == MODE_BOTH) state_next = ST_LL0;
                else if (mode_reg == MODE_DEADTIME) state_next = ST_DT0;
                else state_next = ST_CLAMP;
            end
            ST_LL0: begin
                if (lag_cfg_reg != '0) state_next = ST_DEN;
                else if (lead_reg == '0) state_next = after_ll;
                else state_next = ST_LAGW;
            end
            ST_LAGW:  state_next = ST_DEN;
            ST_DEN:   state_next = ST_CA;
            ST_CA:    state_next = ST_CAW;
            ST_CAW:   if (div_rsp.done) state_next = ST_CB;
            ST_CB:    state_next = ST_CBW;
            ST_CBW:   if (div_rsp.done) state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = after_ll;
            ST_DT0:   state_next = (dead_reg == '0) ? ST_CLAMP : ST_DTW;
            ST_DTW: begin
                if (div_rsp.done) state_next = (div_rsp.quo == '0) ? ST_CLAMP : ST_WR;
            end
            ST_WR:    state_next = ST_RD;
            ST_RD:    state_next = ST_RDU;
            ST_RDU:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_COMB;
            ST_COMB:  state_next = (combine_reg == COMBINE_ADD) ? ST_OUT : ST_COMB2;
            ST_COMB2: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gain_reg       <= 32'sd65536;
            lead_reg       <= '0;
            lag_cfg_reg    <= '0;
            dead_reg       <= '0;
            out_min_reg    <= 32'sh80000000;
            out_max_reg    <= 32'sh7fffffff;
            mode_reg       <= '0;
            combine_reg    <= COMBINE_ADD;
            mem_reg        <= '0;
            wp_reg         <= '0;
            ring_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_GAIN:    gain_reg    <= cfg_wdata;
                    REG_LEAD:    lead_reg    <= cfg_wdata;
                    REG_LAG:     lag_cfg_reg <= cfg_wdata;
                    REG_DEAD:    dead_reg    <= cfg_wdata;
                    REG_OUT_MIN: out_min_reg <= cfg_wdata;
                    REG_OUT_MAX: out_max_reg <= cfg_wdata;
                    REG_MODE:    mode_reg    <= cfg_wdata[2:0];
                    REG_COMBINE: combine_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (state_reg == ST_M4) mem_reg <= sat_r16(sum_reg);
            if (state_reg == ST_WR) begin
                ring_valid_reg[wp_reg] <= 1'b1;
                wp_reg <= wp_inc;
            end
            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // delay ring: write in ST_WR, then read in ST_RD
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) ring_mem[wp_reg] <= x_reg;
        if (state_reg == ST_RD) begin
            rdata_reg  <= ring_mem[rd_addr];
            rvalid_reg <= ring_valid_reg[rd_addr];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    master_reg <= s_tdata[31:0];
                    fb_reg     <= s_tdata[63:32];
                    step_reg   <= s_tdata[95:64];
                    total_reg  <= '0;
                    ff_reg     <= '0;
                    status_reg <= (s_tdata[95:64] == '0) ? STATUS_BAD_STEP : STATUS_OK;
                end
            end
            ST_MULG:  pa_reg <= mul_p;
            ST_RAW:   x_reg <= sat_r16(66'(pa_reg));
            ST_LL0: begin
                lag_reg      <= lag_cfg_reg;
                lag_prod_reg <= 64'(lag_half) * 64'(LAG_RECIP);
            end
            ST_LAGW:  lag_reg <= (lag_q < step_reg) ? step_reg : lag_q;
            ST_DEN:   den_reg <= (DIV_DEN_W'(lag_reg) << 1) + DIV_DEN_W'(step_reg);
            ST_CA:    ca_neg_reg <= lag_diff[33];
            ST_CAW:   if (div_rsp.done) ca_reg <= coef;
            ST_CB:    ca_neg_reg <= 1'b0;
            ST_CBW:   if (div_rsp.done) cb_reg <= coef;
            ST_M1:    pa_reg <= mul_p;
            ST_M2:    pb_reg <= mul_p;
            ST_M3:    sum_reg <= 66'(pa_reg) + 66'(pb_reg);
            ST_M4:    x_reg <= sat_r16(sum_reg);
            ST_DTW: begin
                if (div_rsp.done) begin
                    steps_reg <= (div_rsp.quo >= DIV_NUM_W'(DELAY_DEPTH - 1))
                               ? RING_LAST : div_rsp.quo[RING_AW-1:0];
                end
            end
            ST_RDU:   x_reg <= rvalid_reg ? rdata_reg : '0;
            ST_CLAMP: ff_reg <= clamp_v;
            ST_COMB: begin
                total_reg <= add_sat;
                pa_reg    <= mul_p;
            end
            ST_COMB2: total_reg <= sat_r16(66'(pa_reg));
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg <= {ff_reg, total_reg};
                    m_user_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    `RFFL_ASSERT_IMP(a_div_done_waited, div_rsp.done,
        state_reg == ST_CAW || state_reg == ST_CBW || state_reg == ST_DTW)
    `RFFL_ASSERT_IMP(a_bad_step_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    `RFFL_ASSERT_NXT(a_wp_moves_on_write, state_reg != ST_WR, wp_reg == $past(wp_reg))
    `RFFL_ASSERT_NXT(a_out_held, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule
`default_nettype wire

FILE: tb/sv/tb_ratio_feedforward_lead_lag_deadtime.sv
// Self-checking testbench of the ratio feedforward lead-lag dead-time compensator.
`timescale 1ns / 1ps
module tb_ratio_feedforward_lead_lag_deadtime;
    import rffl_pkg::*;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;
    localparam logic [CFG_AW-1:0] REG_NONE = 4'd9;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    typedef struct {
        logic [31:0] total;
        logic [31:0] ff;
        logic        status;
    } drive_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;
    logic [0:0]        m_tuser;

    ratio_feedforward_lead_lag_deadtime dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    longint      gain_q;
    longint      lead_q, lag_q, dead_q;
    longint      min_q, max_q;
    logic [2:0]  mode_q;
    logic        comb_q;
    longint      filt_mem;
    longint      ring [DELAY_DEPTH];
    int          ring_wr;

    drive_t      drive_fifo[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_bad_step = 0;
    int          hold_off = 0;
    bit          ready_free = 0;
    bit          valid_free = 0;

    function automatic longint clip(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // shift right by 16, ties toward plus infinity
    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint coef(longint n, longint d);
        longint m, q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        if (q > SMAX) q = SMAX;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint run_leadlag(longint x, longint step);
        longint lg, den, ca, cb;
        lg = lag_q;
        if (lg == 0) begin
            if (lead_q == 0) return x;
            lg = (lead_q + 5) / 10;
            if (lg < step) lg = step;
        end
        den = 2 * lg + step;
        ca = coef(2 * (lg - lead_q) * ONE_Q, den);
        cb = coef((2 * lead_q + step) * ONE_Q, den);
        filt_mem = clip(rnd16(ca * filt_mem + cb * x));
        return filt_mem;
    endfunction

    function automatic longint run_delay(longint x, longint step);
        longint steps;
        if (dead_q == 0) return x;
        steps = (2 * dead_q + step) / (2 * step);
        if (steps >= DELAY_DEPTH) steps = DELAY_DEPTH - 1;
        if (steps < 1) return x;
        ring[ring_wr] = x;
        ring_wr = (ring_wr + 1) % DELAY_DEPTH;
        return ring[(ring_wr + DELAY_DEPTH - steps) % DELAY_DEPTH];
    endfunction

    function automatic drive_t compute_drive(logic [95:0] d);
        drive_t r;
        longint master, fb, step, ff, tot;
        master = longint'($signed(d[31:0]));
        fb = longint'($signed(d[63:32]));
        step = longint'({32'd0, d[95:64]});
        if (step == 0) begin
            r.total = '0; r.ff = '0; r.status = STATUS_BAD_STEP;
            return r;
        end
        ff = clip(rnd16(gain_q * master));
        case (mode_q)
            MODE_LEADLAG:  ff = run_leadlag(ff, step);
            MODE_DEADTIME: ff = run_delay(ff, step);
            MODE_BOTH:     ff = run_delay(run_leadlag(ff, step), step);
            default: ;
        endcase
        if (ff > max_q) ff = max_q;
        if (ff < min_q) ff = min_q;
        if (comb_q == COMBINE_ADD) tot = clip(ff + fb);
        else tot = clip(rnd16(ff * (fb + ONE_Q)));
        r.total = tot[31:0]; r.ff = ff[31:0]; r.status = STATUS_OK;
        return r;
    endfunction

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GAIN:    gain_q = longint'($signed(val));
            REG_LEAD:    lead_q = longint'({32'd0, val});
            REG_LAG:     lag_q = longint'({32'd0, val});
            REG_DEAD:    dead_q = longint'({32'd0, val});
            REG_OUT_MIN: min_q = longint'($signed(val));
            REG_OUT_MAX: max_q = longint'($signed(val));
            REG_MODE:    mode_q = val[2:0];
            REG_COMBINE: comb_q = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(logic [31:0] master, logic [31:0] fb, logic [31:0] step);
        @(negedge aclk);
        while (!valid_free && $urandom_range(99) < 23) @(negedge aclk);
        s_tdata <= {step, fb, master};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        drive_fifo.push_back(compute_drive({step, fb, master}));
        n_items++;
        if ({step} == 0) n_bad_step++;
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every result, then let the block settle before reconfiguring
    task automatic drain();
        while (drive_fifo.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_step();
        case ($urandom_range(5))
            0: return $urandom_range(32'h0001_0000, 32'h0004_0000);
            1: return $urandom();
            2: return $urandom_range(1, 255);
            default: return $urandom_range(32'h0000_4000, 32'h0002_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        if ($urandom_range(3) == 0) return $urandom();
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    task automatic test_directed();
        logic [31:0] edges [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        foreach (edges[i]) send_item(edges[i], edges[3 - i], 32'h0001_0000);
        send_item(32'h0001_0000, 32'h0, 32'h0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_COMBINE, COMBINE_MUL);
        write_reg(REG_OUT_MIN, 32'h0001_0000);
        write_reg(REG_OUT_MAX, 32'hFFFF_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
        drain();
        write_reg(REG_OUT_MIN, 32'h8000_0000);
        write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
        write_reg(REG_GAIN, 32'h0001_0000);
        write_reg(REG_COMBINE, COMBINE_ADD);
        // zero lag with lead: substitute lag rule
        write_reg(REG_MODE, MODE_LEADLAG);
        write_reg(REG_LEAD, 32'h0004_0000);
        for (int i = 0; i < 4; i++) send_item(32'h0001_0000 << i, 0, 32'h0001_0000);
        send_item(32'h0001_0000, 0, 32'h0);
        drain();
        write_reg(REG_LEAD, 0);
        send_item(32'h0003_0000, 0, 32'h0001_0000);
        drain();
        write_reg(REG_MODE, MODE_DEADTIME);
        write_reg(REG_DEAD, 32'h0003_0000);
        for (int i = 0; i < 5; i++) send_item(i << 16, 0, 32'h0001_0000);
        send_item(32'h0001_0000, 0, 32'h0100_0000);
        drain();
        write_reg(REG_MODE, MODE_SPARE);
        write_reg(REG_NONE, 32'h1234_5678);
        send_item(32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        drain();
    endtask

    task automatic test_random_phase(int count);
        write_reg(REG_GAIN, ($urandom_range(3) == 0) ? $urandom()
                            : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
        write_reg(REG_LEAD, ($urandom_range(4) == 0) ? 0 : $urandom_range(0, 32'h0010_0000));
        write_reg(REG_LAG, ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 32'h0010_0000));
        write_reg(REG_DEAD, ($urandom_range(5) == 0) ? $urandom()
                            : $urandom_range(0, 32'h0040_0000));
        if ($urandom_range(3) == 0) begin
            write_reg(REG_OUT_MIN, $urandom());
            write_reg(REG_OUT_MAX, $urandom());
        end else begin
            write_reg(REG_OUT_MIN, 32'h8000_0000);
            write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
        end
        write_reg(REG_MODE, $urandom_range(7));
        write_reg(REG_COMBINE, $urandom_range(1));
        for (int i = 0; i < count; i++)
            send_item(rand_sample(), ($urandom_range(3) == 0) ? $urandom()
                      : $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                      ($urandom_range(30) == 0) ? 32'h0 : rand_step());
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODE, MODE_STATIC);
        hold_off = 400;
        for (int i = 0; i < 20; i++) send_item($urandom(), $urandom(), rand_step());
        drain();
    endtask

    task automatic test_no_idle();
        ready_free = 1; valid_free = 1;
        test_random_phase(100);
        ready_free = 0; valid_free = 0;
    endtask

    // receiver: random stalls, plus one long counted hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ready_free || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge aclk) begin
        drive_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (drive_fifo.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = drive_fifo.pop_front();
                if (m_tdata[31:0] !== want.total) begin
                    $error("total_drive expected %h actual %h", want.total, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.ff) begin
                    $error("ff_part expected %h actual %h", want.ff, m_tdata[63:32]);
                    errors++;
                end
                if (m_tuser[0] !== want.status) begin
                    $error("status expected %b actual %b", want.status, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        gain_q = ONE_Q; lead_q = 0; lag_q = 0; dead_q = 0;
        min_q = SMIN; max_q = SMAX; mode_q = 0; comb_q = 0;
        filt_mem = 0; ring_wr = 0;
        foreach (ring[i]) ring[i] = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_no_idle();
        for (int p = 0; p < 30; p++) test_random_phase(50);
        if (drive_fifo.size() != 0) begin
            $error("%0d results never arrived", drive_fifo.size());
            errors++;
        end
        $display("covered %0d items (%0d with zero step), %0d results checked,",
                 n_items, n_bad_step, n_results);
        $display("all modes, both combines, clamp extremes and a long output stall");
        if (errors == 0)
            $display("ratio_feedforward_lead_lag_deadtime regression: pass");
        else
            $display("ratio_feedforward_lead_lag_deadtime regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("ratio_feedforward_lead_lag_deadtime regression: fail");
        $finish;
    end
endmodule
